// ----- design/xrr_pkg.sv -----
// Shared constants, types and the state update function for the xorshift range generator.
package xrr_pkg;

  localparam logic [63:0] SEED_MULT  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] STATE_INIT = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] OUT_MULT   = 64'h2545_F491_4F6C_DD1D;

  localparam int unsigned SHIFT_A  = 12;
  localparam int unsigned SHIFT_B  = 25;
  localparam int unsigned SHIFT_C  = 27;
  localparam int unsigned FRAC_LSB = 11;

  localparam int unsigned INT_W  = 32;
  localparam int unsigned FRAC_W = 53;
  localparam int unsigned IN_W   = 64;
  localparam int unsigned OUT_W  = 88;

  // Request kinds carried on the input tuser
  localparam logic OP_INT  = 1'b0;
  localparam logic OP_FRAC = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEED = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_REM  = 5'b01000,
    ST_WAIT = 5'b10000
  } xrr_state_t;

  // One xorshift step with the (12,25,27) triple
  function automatic logic [63:0] xorshift_step(input logic [63:0] x);
    logic [63:0] a;
    logic [63:0] b;
    a = x ^ (x >> SHIFT_A);
    b = a ^ (a << SHIFT_B);
    return b ^ (b >> SHIFT_C);
  endfunction

endpackage

// ----- design/xrr_mul.sv -----
// Bit-serial shift-add multiplier, 64x64 keeping the low 64 bits, one multiplier bit per cycle.
module xrr_mul
  import xrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] multiplier,
  input  logic [63:0] multiplicand,
  output logic        done,
  output logic [63:0] product
);

  logic [63:0] acc;
  logic [63:0] mplier;
  logic [63:0] mcand;
  logic [5:0]  cnt;
  logic        busy;

  // Control: run 64 steps after start, pulse done once at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand when the current multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mplier <= multiplier;
      mcand  <= multiplicand;
    end else if (busy) begin
      acc    <= acc + (mplier[0] ? mcand : 64'd0);
      mplier <= mplier >> 1;
      mcand  <= mcand << 1;
    end
  end

  assign product = acc;

endmodule

// ----- design/xrr_rem.sv -----
// Bit-serial restoring remainder of a 64-bit dividend by a 33-bit divisor, one bit per cycle.
module xrr_rem
  import xrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic [32:0] rem;
  logic [63:0] dvd;
  logic [32:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic [33:0] diff;

  // Bring down the next dividend bit and try a subtract
  assign trial = {rem, dvd[63]};
  assign diff  = trial - {1'b0, dvs};

  // Control: 64 steps, done pulses after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: keep the difference when the trial value reaches the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (diff[33]) begin
        rem <= trial[32:0];
      end else begin
        rem <= diff[32:0];
      end
    end
  end

  // Remainder stays below the divisor, at most 2^32 - 1
  assign remainder = rem[31:0];

endmodule

// ----- design/xorshift_random_range_core.sv -----
// Top level of the xorshift64* generator answering integer-range and fraction requests.
//
// One request at a time. A fraction request runs the bit-serial 64-bit output multiply
// before its result is formed; an integer request with a real range runs the multiply
// followed by the bit-serial 64-bit remainder by the span; an integer request with
// range_high <= range_low returns range_low without advancing the generator. A seed
// write holds s_tready low while the multiplier forms the new state. The result waits
// in the output register, and the next request is taken while it waits.
module xorshift_random_range_core
  import xrr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // Request stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // [31:0] range_low, [63:32] range_high
  input  logic             s_tuser,   // [0] op
  // Result stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // [31:0] int_value, [84:32] fraction, [87:85] zero
  // Seed register
  input  logic             cfg_wen,
  input  logic [31:0]      cfg_wdata
);

  xrr_state_t  state;
  logic [63:0] gen_state;
  logic        op_q;
  logic        trivial_q;
  logic [31:0] lo_q;
  logic [32:0] span_q;

  logic        s_xfer;
  logic        out_free;
  logic [31:0] req_lo;
  logic [31:0] req_hi;
  logic        req_trivial;
  logic [32:0] req_span;
  logic [63:0] xs;
  logic        need_adv;

  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_prod;
  logic [63:0] seeded;

  logic        rem_start;
  logic        rem_done;
  logic [31:0] rem_val;

  logic [INT_W-1:0]  res_int;
  logic [FRAC_W-1:0] res_frac;

  // Decode the request
  assign req_lo      = s_tdata[31:0];
  assign req_hi      = s_tdata[63:32];
  assign req_trivial = ($signed(req_hi) <= $signed(req_lo));
  assign req_span    = {req_hi[31], req_hi} - {req_lo[31], req_lo} + 33'd1;
  assign xs          = xorshift_step(gen_state);
  assign need_adv    = (s_tuser == OP_FRAC) || !req_trivial;

  assign s_tready = (state == ST_IDLE) && !cfg_wen;
  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Share the multiplier between seed loading and output scrambling
  assign mul_start = cfg_wen || (s_xfer && need_adv);
  assign mul_a     = cfg_wen ? {32'd0, cfg_wdata} : xs;
  assign mul_b     = cfg_wen ? SEED_MULT : OUT_MULT;
  assign seeded    = mul_prod + 64'd1;
  assign rem_start = (state == ST_MUL) && mul_done && (op_q == OP_INT);

  xrr_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplier   (mul_a),
    .multiplicand (mul_b),
    .done         (mul_done),
    .product      (mul_prod)
  );

  xrr_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (mul_prod),
    .divisor   (span_q),
    .done      (rem_done),
    .remainder (rem_val)
  );

  // Form the result fields for the finished request
  always_comb begin
    res_int  = '0;
    res_frac = '0;
    if (op_q == OP_FRAC) begin
      res_frac = mul_prod[63:FRAC_LSB];
    end else if (trivial_q) begin
      res_int = lo_q;
    end else begin
      res_int = lo_q + rem_val;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (cfg_wen) begin
      state <= ST_SEED;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            state <= need_adv ? ST_MUL : ST_WAIT;
          end
        end
        ST_SEED: begin
          if (mul_done) begin
            state <= ST_IDLE;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= (op_q == OP_FRAC) ? ST_WAIT : ST_REM;
          end
        end
        ST_REM: begin
          if (rem_done) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Generator state: reset constant, advance on each fraction or real-range transfer, reload from seed
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= STATE_INIT;
    end else if (s_xfer && need_adv) begin
      gen_state <= xs;
    end else if ((state == ST_SEED) && mul_done && !cfg_wen) begin
      gen_state <= (seeded == 64'd0) ? 64'd1 : seeded;
    end
  end

  // Hold the request fields for the run
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      op_q      <= s_tuser;
      trivial_q <= req_trivial;
      lo_q      <= req_lo;
      span_q    <= req_span;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_WAIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_WAIT) && out_free) begin
      m_tdata <= {3'd0, res_frac, res_int};
    end
  end

endmodule

// ----- design/xrr_checker.sv -----
// Port-level checker for the xorshift range generator, bound to the top level.
module xrr_checker
  import xrr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             cfg_wen
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // One request in flight: busy after each input transfer and after each seed write
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) || cfg_wen |=> !s_tready)
    else $error("request taken while busy");

  // A result carries only one of its two fields
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:0] == 32'd0) || (m_tdata[84:32] == 53'd0))
    else $error("both result fields nonzero");

endmodule

bind xorshift_random_range_core xrr_checker u_xrr_checker (.*);

// ----- verif/tb_xorshift_random_range_core.sv -----
// Self-checking testbench for the xorshift64* range generator: directed, seeded and random requests.
`timescale 1ns / 100ps

module tb_xorshift_random_range_core;
  import xrr_pkg::*;

  localparam logic [31:0] INT_MIN     = 32'h8000_0000;
  localparam logic [31:0] INT_MAX     = 32'h7FFF_FFFF;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_TAIL  = 150;

  // Expected result of one request
  typedef struct packed {
    logic [INT_W-1:0]  int_value;
    logic [FRAC_W-1:0] fraction;
  } rng_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = OP_INT;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_wen = 1'b0;
  logic [31:0]      cfg_wdata = '0;

  // Predictor state and bookkeeping
  logic [63:0]  gen_state;
  rng_result_t  pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  ready_hold_cycles = 0;
  bit           sender_gaps_off = 1'b0;
  bit           receiver_gaps_off = 1'b0;

  xorshift_random_range_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Advance the generator copy and return the multiplied output
  function automatic logic [63:0] advance_generator();
    logic [63:0] x;
    x = gen_state;
    x = x ^ (x >> SHIFT_A);
    x = x ^ (x << SHIFT_B);
    x = x ^ (x >> SHIFT_C);
    gen_state = x;
    return x * OUT_MULT;
  endfunction

  // Work out the result of one request, updating the generator copy
  function automatic rng_result_t predict_random(input logic op, input logic [31:0] lo,
                                                 input logic [31:0] hi);
    rng_result_t      res;
    logic [63:0]      r;
    logic signed [63:0] lo_wide;
    logic signed [63:0] hi_wide;
    logic [63:0]      span;
    res = '0;
    if (op == OP_FRAC) begin
      r = advance_generator();
      res.fraction = r[63:FRAC_LSB];
    end else if ($signed(hi) <= $signed(lo)) begin
      res.int_value = lo;
    end else begin
      lo_wide = $signed(lo);
      hi_wide = $signed(hi);
      span = hi_wide - lo_wide + 64'sd1;
      r = advance_generator();
      r = r % span;
      res.int_value = lo + r[31:0];
    end
    return res;
  endfunction

  // Offer one request after a random gap; leave tvalid high after the transfer
  task automatic send_request(input logic op, input logic [31:0] lo, input logic [31:0] hi);
    int unsigned gap;
    gap = sender_gaps_off ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {hi, lo};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_random(op, lo, hi));
  endtask

  // Drop tvalid and hold until every expected result has arrived
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write the seed register while idle and reload the generator copy
  task automatic load_seed(input logic [31:0] value);
    logic [63:0] s;
    wait_for_results();
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    s = {32'b0, value} * SEED_MULT + 64'd1;
    gen_state = (s == 64'd0) ? 64'd1 : s;
  endtask

  // Pick a bound from the signed extremes and their neighbors
  function automatic logic [31:0] extreme_bound();
    case ($urandom_range(0, 6))
      0: return INT_MIN;
      1: return INT_MIN + 32'd1;
      2: return INT_MAX;
      3: return INT_MAX - 32'd1;
      4: return 32'hFFFF_FFFF;
      5: return 32'd0;
      default: return 32'd1;
    endcase
  endfunction

  // Random requests, mostly real integer ranges and fractions
  task automatic send_random_requests(input int unsigned count);
    logic        op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] t;
    int unsigned kind;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      op = OP_INT;
      a = $urandom();
      b = $urandom();
      case (kind)
        0, 1, 2, 3: op = OP_FRAC;
        4, 5: begin
          // short span anchored anywhere
          b = a + $urandom_range(1, 16);
          if ($signed(b) < $signed(a)) begin
            t = a; a = b; b = t;
          end
        end
        6: begin
          b = a + $urandom_range(17, 1 << 20);
          if ($signed(b) < $signed(a)) begin
            t = a; a = b; b = t;
          end
        end
        7: begin
          if ($signed(b) < $signed(a)) begin
            t = a; a = b; b = t;
          end
        end
        8: begin
          // empty or single-value range
          if ($urandom_range(0, 1) == 0) b = a;
          else if ($signed(b) > $signed(a)) begin
            t = a; a = b; b = t;
          end
        end
        default: begin
          a = extreme_bound();
          b = extreme_bound();
        end
      endcase
      send_request(op, a, b);
    end
  endtask

  task automatic test_reset_state();
    send_request(OP_FRAC, 32'd0, 32'd0);
    send_request(OP_INT, 32'd0, 32'd9);
    send_request(OP_FRAC, INT_MAX, INT_MIN);
    send_request(OP_INT, INT_MIN, INT_MAX);
    wait_for_results();
  endtask

  task automatic test_directed_ranges();
    // full 32-bit span
    send_request(OP_INT, INT_MIN, INT_MAX);
    send_request(OP_INT, INT_MIN, INT_MAX);
    // single value and empty ranges leave the generator alone
    send_request(OP_INT, 32'd5, 32'd5);
    send_request(OP_INT, INT_MIN, INT_MIN);
    send_request(OP_INT, INT_MAX, INT_MIN);
    send_request(OP_INT, 32'd0, 32'hFFFF_FFFF);
    // two-value spans at the edges
    send_request(OP_INT, 32'd0, 32'd1);
    send_request(OP_INT, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_INT, INT_MAX - 32'd1, INT_MAX);
    send_request(OP_INT, INT_MIN, INT_MIN + 32'd1);
    // fraction ignores the bounds
    send_request(OP_FRAC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_FRAC, $urandom(), $urandom());
    wait_for_results();
  endtask

  task automatic test_seed_extremes();
    load_seed(32'd0);
    send_request(OP_FRAC, 32'd0, 32'd0);
    send_request(OP_INT, INT_MIN, INT_MAX);
    send_request(OP_INT, 32'hFFFF_FFF0, 32'd15);
    load_seed(32'hFFFF_FFFF);
    send_request(OP_FRAC, INT_MIN, INT_MAX);
    send_request(OP_INT, 32'd0, 32'd99);
    send_request(OP_INT, INT_MIN, INT_MAX);
    wait_for_results();
  endtask

  task automatic test_random_phases();
    repeat (5) begin
      load_seed($urandom());
      send_random_requests(96);
    end
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    // receiver holds off while the sender keeps offering, then the sender pauses
    sender_gaps_off = 1'b1;
    ready_hold_cycles = 400;
    send_random_requests(8);
    sender_gaps_off = 1'b0;
    wait_for_results();
    repeat (20) @(posedge clk);
    send_random_requests(4);
    wait_for_results();
  endtask

  task automatic test_no_idle();
    sender_gaps_off = 1'b1;
    receiver_gaps_off = 1'b1;
    load_seed($urandom());
    send_random_requests(30);
    wait_for_results();
    sender_gaps_off = 1'b0;
    receiver_gaps_off = 1'b0;
  endtask

  // Accept results with random ready gaps and check each against the oldest expectation
  initial begin
    int unsigned gap;
    rng_result_t want;
    logic [INT_W-1:0]  got_int;
    logic [FRAC_W-1:0] got_frac;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (ready_hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (ready_hold_cycles) @(posedge clk);
        ready_hold_cycles = 0;
      end
      gap = receiver_gaps_off ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid && ready_hold_cycles == 0) @(posedge clk);
      if (m_tvalid) begin
        got_int  = m_tdata[INT_W-1:0];
        got_frac = m_tdata[INT_W +: FRAC_W];
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: int_value %h fraction %h", got_int, got_frac);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got_int !== want.int_value) begin
            $error("int_value: expected %h, actual %h", want.int_value, got_int);
            error_count++;
          end
          if (got_frac !== want.fraction) begin
            $error("fraction: expected %h, actual %h", want.fraction, got_frac);
            error_count++;
          end
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    gen_state = STATE_INIT;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed_ranges();
    test_seed_extremes();
    test_random_phases();
    test_output_backpressure();
    test_no_idle();
    wait_for_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
